// ----- rtl/lpm_pkg.sv -----
package lpm_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int ADDR_W       = 32;
   localparam int LEN_W        = 6;
   localparam int IFACE_W      = 8;
   localparam int FUNC_W       = 2;
   localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  prefix;
      logic [LEN_W-1:0]   len;
      logic [ADDR_W-1:0]  hop;
      logic [IFACE_W-1:0] iface;
   } entry_type;

   // what travels down the cell chain with one item
   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] key;    // masked prefix, or destination for a lookup
      logic [LEN_W-1:0]  len;
      logic              found;  // add/remove: exact route seen
      logic              hit;    // lookup: some route covers key
      entry_type         best;
      entry_type         last;   // copy of the highest live entry
   } token_type;

   typedef struct packed {
      logic      en;
      entry_type entry;
   } wr_type;

   // top len bits set; zero length gives zero, 32 and above give all ones
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      if (len == '0) begin
         m = '0;
      end else if (len >= LEN_MAX) begin
         m = '1;
      end else begin
         m = ~({ADDR_W{1'b1}} >> len);
      end
      return m;
   endfunction

endpackage

// ----- rtl/lpm_cell.sv -----
module lpm_cell #(
   parameter int  CAPACITY = lpm_pkg::CAPACITY_DEF,
   parameter int  IDX      = 0,
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_valid_in,
   input  lpm_pkg::token_type    tok_in,
   input  logic [IDX_W-1:0]      tok_idx_in,
   output logic                  tok_valid_out,
   output lpm_pkg::token_type    tok_out,
   output logic [IDX_W-1:0]      tok_idx_out,
   input  logic [CNT_W-1:0]      route_count,
   input  lpm_pkg::wr_type       wr,
   input  logic [IDX_W-1:0]      wr_idx
);
   import lpm_pkg::*;

   entry_type         entry_ff;
   logic              tok_valid_ff;
   token_type         tok_ff, tok_in_next;
   logic [IDX_W-1:0]  tok_idx_ff, tok_idx_next;
   logic              in_use, is_last, key_hit, pfx_hit;
   logic [ADDR_W-1:0] mask;

   assign in_use  = CNT_W'(IDX) < route_count;
   assign is_last = CNT_W'(IDX + 1) == route_count;
   assign key_hit = (entry_ff.len == tok_in.len) && (entry_ff.prefix == tok_in.key);
   assign mask    = len_mask(entry_ff.len);
   assign pfx_hit = (tok_in.key & mask) == entry_ff.prefix;

   always_comb begin
      tok_in_next  = tok_in;
      tok_idx_next = tok_idx_in;
      if (in_use) begin
         if ((tok_in.func == FUNC_ADD || tok_in.func == FUNC_REMOVE)
               && !tok_in.found && key_hit) begin
            tok_in_next.found = 1'b1;
            tok_idx_next      = IDX_W'(IDX);
         end
         // strict compare keeps the lowest index on equal lengths
         if (tok_in.func == FUNC_LOOKUP && pfx_hit
               && (!tok_in.hit || entry_ff.len > tok_in.best.len)) begin
            tok_in_next.hit  = 1'b1;
            tok_in_next.best = entry_ff;
         end
         if (is_last) begin
            tok_in_next.last = entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff     <= tok_in_next;
      tok_idx_ff <= tok_idx_next;
      if (wr.en && wr_idx == IDX_W'(IDX)) begin
         entry_ff <= wr.entry;
      end
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_out       = tok_ff;
   assign tok_idx_out   = tok_idx_ff;

endmodule

// ----- rtl/longest_prefix_match_route_table.sv -----
// Channel | Dir | Ports                      | Payload
// req     | in  | req_tvalid/tready/tdata/   | one operation: add, remove or lookup
//         |     | tuser                      |
// rsp     | out | rsp_tvalid/tready/tdata/   | one result per operation
//         |     | tuser                      |
//
// Each item walks the row of CAPACITY route cells, one cell per cycle; the walk is the
// bottleneck. Only one item is in the row at a time; the table update lands when its
// result loads. Reset clears the route count and the chain valid bits; route entries
// hold no reset. A held result does not block accepting the next item; its walk
// finishes and then waits in the done state until the output register frees up.
module longest_prefix_match_route_table #(
   parameter int  CAPACITY = lpm_pkg::CAPACITY_DEF,
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // route_prefix[31:0], route_len[37:32], hop_in[69:38], iface_in[77:70],
   // dest_addr[109:78], zero pad
   input  logic [lpm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // func[1:0]
   input  logic [lpm_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // match_prefix[31:0], match_len[37:32], hop_out[69:38], iface_out[77:70], zero pad
   output logic [lpm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status[0], hit[1]
   output logic [lpm_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import lpm_pkg::*;

   // request fields
   logic [ADDR_W-1:0]  req_prefix, req_dest, req_hop;
   logic [LEN_W-1:0]   req_len;
   logic [IFACE_W-1:0] req_iface;
   func_type           req_func;
   logic               req_fire;

   assign req_prefix = req_tdata[31:0];
   assign req_len    = req_tdata[37:32];
   assign req_hop    = req_tdata[69:38];
   assign req_iface  = req_tdata[77:70];
   assign req_dest   = req_tdata[109:78];
   assign req_func   = func_type'(req_tuser);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   route_count_ff, route_count_in;
   logic [ADDR_W-1:0]  hop_ff;
   logic [IFACE_W-1:0] iface_ff;
   token_type          hold_ff;
   logic [IDX_W-1:0]   hold_idx_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0] rsp_tuser_ff, rsp_tuser_in;
   logic               done_fire;
   wr_type             wr;
   logic [IDX_W-1:0]   wr_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign done_fire  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // cell row: position 0 is the incoming item, position CAPACITY the tail
   logic [CAPACITY:0] tok_valid;
   token_type         tok [CAPACITY+1];
   logic [IDX_W-1:0]  tok_idx [CAPACITY+1];
   token_type         tok_head;

   always_comb begin
      tok_head      = '0;
      tok_head.func = req_func;
      tok_head.len  = req_len;
      tok_head.key  = (req_func == FUNC_LOOKUP) ? req_dest : (req_prefix & len_mask(req_len));
   end

   assign tok[0]       = tok_head;
   assign tok_valid[0] = req_fire;
   assign tok_idx[0]   = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lpm_cell #(
         .CAPACITY (CAPACITY),
         .IDX      (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .tok_valid_in  (tok_valid[i]),
         .tok_in        (tok[i]),
         .tok_idx_in    (tok_idx[i]),
         .tok_valid_out (tok_valid[i+1]),
         .tok_out       (tok[i+1]),
         .tok_idx_out   (tok_idx[i+1]),
         .route_count   (route_count_ff),
         .wr            (wr),
         .wr_idx        (wr_idx)
      );
   end

   // next state, table update and result
   always_comb begin
      state_in       = state_ff;
      route_count_in = route_count_ff;
      wr             = '0;
      wr_idx         = hold_idx_ff;
      rsp_tdata_in   = '0;
      rsp_tuser_in   = '0;   // {hit, status}

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (tok_valid[CAPACITY]) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            unique case (hold_ff.func)
               FUNC_ADD: begin
                  if (hold_ff.len > LEN_MAX) begin
                     rsp_tuser_in[0] = 1'b1;
                  end else if (hold_ff.found) begin
                     // overwrite in place
                     wr.en = 1'b1;
                  end else if (route_count_ff == CNT_W'(CAPACITY)) begin
                     rsp_tuser_in[0] = 1'b1;
                  end else begin
                     wr.en          = 1'b1;
                     wr_idx         = route_count_ff[IDX_W-1:0];
                     route_count_in = route_count_ff + 1'b1;
                  end
                  wr.entry = '{prefix: hold_ff.key, len: hold_ff.len,
                               hop: hop_ff, iface: iface_ff};
               end
               FUNC_REMOVE: begin
                  wr.entry = hold_ff.last;
                  if (hold_ff.len > LEN_MAX || !hold_ff.found) begin
                     rsp_tuser_in[0] = 1'b1;
                  end else begin
                     // last live entry fills the hole
                     wr.en          = 1'b1;
                     route_count_in = route_count_ff - 1'b1;
                  end
               end
               FUNC_LOOKUP: begin
                  if (hold_ff.hit) begin
                     rsp_tuser_in[1] = 1'b1;
                     rsp_tdata_in    = {2'b00, hold_ff.best.iface, hold_ff.best.hop,
                                        hold_ff.best.len, hold_ff.best.prefix};
                  end
               end
               FUNC_NONE: begin
               end
            endcase
            if (done_fire) begin
               state_in = ST_IDLE;
            end else begin
               wr.en          = 1'b0;
               route_count_in = route_count_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         route_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         route_count_ff <= route_count_in;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hop_ff   <= req_hop;
         iface_ff <= req_iface;
      end
      if (state_ff == ST_BUSY && tok_valid[CAPACITY]) begin
         hold_ff     <= tok[CAPACITY];
         hold_idx_ff <= tok_idx[CAPACITY];
      end
      if (done_fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      route_count_ff <= CNT_W'(CAPACITY))
      else $error("route count above capacity");

   a_one_item : assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid[CAPACITY:1]))
      else $error("more than one item in the cell row");

   a_tail_busy : assert property (@(posedge clock) disable iff (reset)
      tok_valid[CAPACITY] |-> state_ff == ST_BUSY)
      else $error("item left the row outside busy");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !done_fire |=> $stable(route_count_ff))
      else $error("route count changed without a result");

   a_write_done : assert property (@(posedge clock) disable iff (reset)
      wr.en |-> done_fire)
      else $error("table write outside result load");
`endif

endmodule
